// File: rtl/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types, codes and helpers for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfp_pkg;

  // Default depth of the queue between classifier and parser
  localparam int unsigned QUEUE_DEPTH = 2;

  // Byte roles
  localparam logic [3:0] ROLE_LEN_HI  = 4'd0;
  localparam logic [3:0] ROLE_LEN_LO  = 4'd1;
  localparam logic [3:0] ROLE_PROTO   = 4'd2;
  localparam logic [3:0] ROLE_PAYLOAD = 4'd3;
  localparam logic [3:0] ROLE_MSGTYPE = 4'd4;
  localparam logic [3:0] ROLE_ATYPE   = 4'd5;
  localparam logic [3:0] ROLE_ALEN    = 4'd6;
  localparam logic [3:0] ROLE_TAG     = 4'd7;
  localparam logic [3:0] ROLE_STRING  = 4'd8;
  localparam logic [3:0] ROLE_UNKNOWN = 4'd9;
  localparam logic [3:0] ROLE_OTHER   = 4'd10;

  // Protocol classes
  localparam logic [2:0] CLS_RSL     = 3'd0;
  localparam logic [2:0] CLS_OML     = 3'd1;
  localparam logic [2:0] CLS_CCM     = 3'd2;
  localparam logic [2:0] CLS_SCCP    = 3'd3;
  localparam logic [2:0] CLS_UNKNOWN = 3'd4;

  // Protocol byte values
  localparam logic [7:0] PROTO_RSL  = 8'h00;
  localparam logic [7:0] PROTO_OML  = 8'hff;
  localparam logic [7:0] PROTO_CCM  = 8'hfe;
  localparam logic [7:0] PROTO_SCCP = 8'hfd;

  // CCM message types that carry attributes
  localparam logic [7:0] MSG_ATTR_A = 8'd4;
  localparam logic [7:0] MSG_ATTR_B = 8'd5;

  // Attribute type codes
  localparam logic [7:0] ATYPE_STRING = 8'h00;
  localparam logic [7:0] ATYPE_ONETAG = 8'h01;

  typedef enum logic [1:0] {
    FP_LEN_HI  = 2'd0,
    FP_LEN_LO  = 2'd1,
    FP_PROTO   = 2'd2,
    FP_PAYLOAD = 2'd3
  } frame_phase_t;

  typedef enum logic [2:0] {
    AP_MSGTYPE = 3'd0,
    AP_TYPE    = 3'd1,
    AP_LEN     = 3'd2,
    AP_TAG     = 3'd3,
    AP_STRING  = 3'd4,
    AP_ONETAG  = 3'd5,
    AP_UNKNOWN = 3'd6,
    AP_OTHER   = 3'd7
  } attr_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  role;
    logic [2:0]  proto_class;
    logic [15:0] payload_offset;
    logic        frame_last;
    logic [7:0]  tag_value;
    logic        truncated;
  } result_t;

  // Byte plus the flags the classifier derives from it
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic [2:0] cls;
    logic       msg_attr;
    logic       is_zero;
    logic       is_one;
  } cls_item_t;

  function automatic logic [2:0] class_of(input logic [7:0] b);
    logic [2:0] c;
    case (b)
      PROTO_RSL:  c = CLS_RSL;
      PROTO_OML:  c = CLS_OML;
      PROTO_CCM:  c = CLS_CCM;
      PROTO_SCCP: c = CLS_SCCP;
      default:    c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lpfp_front.sv
// ----------------------------------------------------------------------------
// lpfp_front
// Input side: accepts stream bytes and tags each with its decode flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_front (
  input  var lpfp_pkg::item_t     item,
  output var lpfp_pkg::cls_item_t cls_item
);
  import lpfp_pkg::*;

  // Classify the byte for every phase that may need it
  always_comb begin
    cls_item.data_byte = item.data_byte;
    cls_item.restart   = item.restart;
    cls_item.cls       = class_of(item.data_byte);
    cls_item.msg_attr  = (item.data_byte == MSG_ATTR_A) || (item.data_byte == MSG_ATTR_B);
    cls_item.is_zero   = (item.data_byte == ATYPE_STRING);
    cls_item.is_one    = (item.data_byte == ATYPE_ONETAG);
  end

endmodule

`default_nettype wire

// File: rtl/lpfp_queue.sv
// ----------------------------------------------------------------------------
// lpfp_queue
// Small FIFO between classifier and parser so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_queue #(
  parameter int unsigned Depth = lpfp_pkg::QUEUE_DEPTH
) (
  input  var logic                clk,
  input  var logic                rst,
  input  var logic                wr_valid,
  output var logic                wr_ready,
  input  var lpfp_pkg::cls_item_t wr_data,
  output var logic                rd_valid,
  input  var logic                rd_ready,
  output var lpfp_pkg::cls_item_t rd_data
);
  import lpfp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  cls_item_t       entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != Full);
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store an incoming transfer
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= Full)
    else $error("queue occupancy above depth");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

// File: rtl/lpfp_back.sv
// ----------------------------------------------------------------------------
// lpfp_back
// Parser: walks framing and CCM attributes, registers one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_back (
  input  var logic                clk,
  input  var logic                rst,
  input  var logic                q_valid,
  output var logic                q_ready,
  input  var lpfp_pkg::cls_item_t q_data,
  output var logic                result_valid,
  input  var logic                result_ready,
  output var lpfp_pkg::result_t   result
);
  import lpfp_pkg::*;

  // Parser state
  frame_phase_t frame_phase, frame_phase_next;
  logic [15:0]  payload_remaining, payload_remaining_next;
  logic [15:0]  payload_position, payload_position_next;
  logic [2:0]   protocol_class, protocol_class_next;
  attr_phase_t  attr_phase, attr_phase_next;
  logic [7:0]   attr_remaining, attr_remaining_next;
  logic [7:0]   current_tag, current_tag_next;
  logic         attr_enabled, attr_enabled_next;

  // State as seen by this byte, after a restart clears it
  frame_phase_t e_fp;
  logic [15:0]  e_rem;
  logic [15:0]  e_pos;
  logic [2:0]   e_pc;
  attr_phase_t  e_ap;
  logic [7:0]   e_arem;
  logic [7:0]   e_tag;
  logic         e_en;

  logic         take;
  result_t      res_next;

  assign take    = q_valid && q_ready;
  assign q_ready = !result_valid || result_ready;

  always_comb begin
    if (q_data.restart) begin
      e_fp   = FP_LEN_HI;
      e_rem  = '0;
      e_pos  = '0;
      e_pc   = CLS_RSL;
      e_ap   = AP_MSGTYPE;
      e_arem = '0;
      e_tag  = '0;
      e_en   = 1'b0;
    end else begin
      e_fp   = frame_phase;
      e_rem  = payload_remaining;
      e_pos  = payload_position;
      e_pc   = protocol_class;
      e_ap   = attr_phase;
      e_arem = attr_remaining;
      e_tag  = current_tag;
      e_en   = attr_enabled;
    end
  end

  // Next state
  always_comb begin
    frame_phase_next       = e_fp;
    payload_remaining_next = e_rem;
    payload_position_next  = e_pos;
    protocol_class_next    = e_pc;
    attr_phase_next        = e_ap;
    attr_remaining_next    = e_arem;
    current_tag_next       = e_tag;
    attr_enabled_next      = e_en;
    case (e_fp)
      FP_LEN_HI: begin
        payload_remaining_next = {q_data.data_byte, 8'h00};
        frame_phase_next       = FP_LEN_LO;
      end
      FP_LEN_LO: begin
        payload_remaining_next = e_rem | {8'h00, q_data.data_byte};
        frame_phase_next       = FP_PROTO;
      end
      FP_PROTO: begin
        protocol_class_next   = q_data.cls;
        payload_position_next = '0;
        attr_phase_next       = AP_MSGTYPE;
        attr_remaining_next   = '0;
        current_tag_next      = '0;
        attr_enabled_next     = 1'b0;
        frame_phase_next      = (e_rem == '0) ? FP_LEN_HI : FP_PAYLOAD;
      end
      FP_PAYLOAD: begin
        payload_position_next  = e_pos + 16'd1;
        payload_remaining_next = e_rem - 16'd1;
        if (e_rem == 16'd1) begin
          frame_phase_next = FP_LEN_HI;
        end
        if (e_pc == CLS_CCM) begin
          case (e_ap)
            AP_MSGTYPE: begin
              if (q_data.msg_attr) begin
                attr_enabled_next = 1'b1;
                attr_phase_next   = AP_TYPE;
              end else begin
                attr_phase_next = AP_OTHER;
              end
            end
            AP_TYPE: begin
              if (q_data.is_zero) begin
                attr_phase_next = AP_LEN;
              end else if (q_data.is_one) begin
                attr_phase_next = AP_ONETAG;
              end else begin
                attr_phase_next = AP_UNKNOWN;
              end
            end
            AP_LEN: begin
              attr_remaining_next = q_data.data_byte;
              attr_phase_next     = q_data.is_zero ? AP_TYPE : AP_TAG;
            end
            AP_TAG: begin
              current_tag_next    = q_data.data_byte;
              attr_remaining_next = e_arem - 8'd1;
              attr_phase_next     = (e_arem == 8'd1) ? AP_TYPE : AP_STRING;
            end
            AP_STRING: begin
              attr_remaining_next = e_arem - 8'd1;
              if (e_arem == 8'd1) begin
                attr_phase_next = AP_TYPE;
              end
            end
            AP_ONETAG: begin
              current_tag_next = q_data.data_byte;
              attr_phase_next  = AP_TYPE;
            end
            AP_UNKNOWN: begin
              attr_phase_next = AP_TYPE;
            end
            default: begin
              attr_phase_next = e_ap;
            end
          endcase
        end
      end
      default: begin
        frame_phase_next = e_fp;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res_next.byte_out       = q_data.data_byte;
    res_next.role           = ROLE_LEN_HI;
    res_next.proto_class    = protocol_class_next;
    res_next.payload_offset = '0;
    res_next.frame_last     = 1'b0;
    res_next.tag_value      = '0;
    res_next.truncated      = q_data.restart && (frame_phase != FP_LEN_HI);
    case (e_fp)
      FP_LEN_HI: res_next.role = ROLE_LEN_HI;
      FP_LEN_LO: res_next.role = ROLE_LEN_LO;
      FP_PROTO: begin
        res_next.role       = ROLE_PROTO;
        res_next.frame_last = (e_rem == '0);
      end
      FP_PAYLOAD: begin
        res_next.payload_offset = e_pos;
        res_next.frame_last     = (e_rem == 16'd1);
        if (e_pc == CLS_CCM) begin
          case (e_ap)
            AP_MSGTYPE: res_next.role = ROLE_MSGTYPE;
            AP_TYPE:    res_next.role = ROLE_ATYPE;
            AP_LEN:     res_next.role = ROLE_ALEN;
            AP_TAG: begin
              res_next.role      = ROLE_TAG;
              res_next.tag_value = q_data.data_byte;
            end
            AP_STRING: begin
              res_next.role      = ROLE_STRING;
              res_next.tag_value = e_tag;
            end
            AP_ONETAG: begin
              res_next.role      = ROLE_TAG;
              res_next.tag_value = q_data.data_byte;
            end
            AP_UNKNOWN: res_next.role = ROLE_UNKNOWN;
            default:    res_next.role = ROLE_OTHER;
          endcase
        end else begin
          res_next.role = ROLE_PAYLOAD;
        end
        // Flag an attribute left open by the frame end
        if ((e_rem == 16'd1) && (e_pc == CLS_CCM) && attr_enabled_next &&
            (attr_phase_next == AP_LEN || attr_phase_next == AP_TAG ||
             attr_phase_next == AP_STRING || attr_phase_next == AP_ONETAG ||
             attr_phase_next == AP_UNKNOWN)) begin
          res_next.truncated = 1'b1;
        end
      end
      default: res_next.role = ROLE_LEN_HI;
    endcase
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase       <= FP_LEN_HI;
      payload_remaining <= '0;
      payload_position  <= '0;
      protocol_class    <= CLS_RSL;
      attr_phase        <= AP_MSGTYPE;
      attr_remaining    <= '0;
      current_tag       <= '0;
      attr_enabled      <= 1'b0;
    end else if (take) begin
      frame_phase       <= frame_phase_next;
      payload_remaining <= payload_remaining_next;
      payload_position  <= payload_position_next;
      protocol_class    <= protocol_class_next;
      attr_phase        <= attr_phase_next;
      attr_remaining    <= attr_remaining_next;
      current_tag       <= current_tag_next;
      attr_enabled      <= attr_enabled_next;
    end
  end

  // Output register: load on transfer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (frame_phase == FP_PAYLOAD) |-> (payload_remaining != '0))
    else $error("payload phase with nothing left");
  a_attr_only_ccm: assert property (@(posedge clk) disable iff (rst)
    attr_enabled |-> (protocol_class == CLS_CCM))
    else $error("attribute walk outside a CCM frame");
  a_trunc_at_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.truncated && result.role != ROLE_LEN_HI) |-> result.frame_last)
    else $error("truncation flagged away from frame end");
`endif

endmodule

`default_nettype wire

// File: rtl/length_prefixed_frame_parser_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_core
// Labels each byte of a length-prefixed frame stream with its role and class.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one stream byte per transfer, with a restart flag that
//   begins framing anew on that byte. result channel: one labeled result per
//   byte, in order (role, protocol class, payload offset, frame end, attribute
//   tag, truncation flag).
//   A taken byte is written into the queue, then moved through the parser
//   into the output register once the parser can take it.
//   Throughput: one byte per cycle sustained while the receiver is ready;
//   the parser state updates once per byte.
//   Reset clears the queue, the parser state and the output valid flag; the
//   first byte after reset is read as a length high byte.
//   When the receiver stalls, the result holds, the parser stops, and the
//   queue absorbs up to QueueDepth bytes before item_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_parser_core #(
  parameter int unsigned QueueDepth = lpfp_pkg::QUEUE_DEPTH
) (
  input  var logic              clk,
  input  var logic              rst,
  input  var logic              item_valid,
  output var logic              item_ready,
  input  var lpfp_pkg::item_t   item,
  output var logic              result_valid,
  input  var logic              result_ready,
  output var lpfp_pkg::result_t result
);
  import lpfp_pkg::*;

  cls_item_t cls_item;
  cls_item_t q_data;
  logic      q_valid;
  logic      q_ready;

  lpfp_front u_front (
    .item     (item),
    .cls_item (cls_item)
  );

  lpfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (item_valid),
    .wr_ready (item_ready),
    .wr_data  (cls_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  lpfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: bench/length_prefixed_frame_parser_core_test.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_core_test
// Streams directed and random frames into the parser, predicts every labeled
// byte from a local copy of the parser state and checks each result transfer
// against the oldest prediction, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module length_prefixed_frame_parser_core_test;
  import lpfp_pkg::*;

  localparam int unsigned N_ITEMS     = 1650;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned MAX_REPORTS = 10;

  // Pacing modes for either side
  localparam int unsigned PACE_FULL  = 0;
  localparam int unsigned PACE_LIGHT = 1;
  localparam int unsigned PACE_HEAVY = 2;

  typedef struct packed {
    item_t it;
    logic  drain;
  } stim_t;

  logic    clk;
  logic    rst;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  stim_t       stim_q[$];
  logic [7:0]  body_q[$];
  result_t     label_q[$];
  logic        drain_next = 1'b0;
  int unsigned mismatches = 0;
  int unsigned tx_gap, tx_mode, tx_count;
  int unsigned rx_gap, rx_mode, rx_count, rx_hold;
  int unsigned idle_cycles;

  // Mirror of the parser state
  frame_phase_t fr_phase;
  logic [15:0]  pay_left;
  logic [15:0]  pay_pos;
  logic [2:0]   frame_cls;
  attr_phase_t  at_phase;
  logic [7:0]   at_left;
  logic [7:0]   cur_tag;
  logic         walk_attrs;

  length_prefixed_frame_parser_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Idle cycles before the next transfer
  function automatic int unsigned pick_gap(input int unsigned mode);
    if (mode == PACE_FULL) return 0;
    if (mode == PACE_LIGHT && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic void clear_parser();
    fr_phase   = FP_LEN_HI;
    pay_left   = '0;
    pay_pos    = '0;
    frame_cls  = CLS_RSL;
    at_phase   = AP_MSGTYPE;
    at_left    = '0;
    cur_tag    = '0;
    walk_attrs = 1'b0;
  endfunction

  // Advance the mirrored parser by one byte and return its label
  function automatic result_t label_byte(input item_t it);
    result_t    r;
    logic [7:0] b;
    b = it.data_byte;
    r = '0;
    r.byte_out = b;
    r.role = ROLE_LEN_HI;
    // Drop any open frame and start over on this byte
    if (it.restart) begin
      r.truncated = (fr_phase != FP_LEN_HI);
      clear_parser();
    end
    case (fr_phase)
      FP_LEN_HI: begin
        pay_left = {b, 8'h00};
        fr_phase = FP_LEN_LO;
      end
      FP_LEN_LO: begin
        r.role = ROLE_LEN_LO;
        pay_left = pay_left | {8'h00, b};
        fr_phase = FP_PROTO;
      end
      FP_PROTO: begin
        r.role = ROLE_PROTO;
        case (b)
          PROTO_RSL:  frame_cls = CLS_RSL;
          PROTO_OML:  frame_cls = CLS_OML;
          PROTO_CCM:  frame_cls = CLS_CCM;
          PROTO_SCCP: frame_cls = CLS_SCCP;
          default:    frame_cls = CLS_UNKNOWN;
        endcase
        pay_pos    = '0;
        at_phase   = AP_MSGTYPE;
        at_left    = '0;
        cur_tag    = '0;
        walk_attrs = 1'b0;
        // An empty payload ends the frame on the protocol byte
        if (pay_left == 16'd0) begin
          r.frame_last = 1'b1;
          fr_phase = FP_LEN_HI;
        end else begin
          fr_phase = FP_PAYLOAD;
        end
      end
      default: begin
        r.payload_offset = pay_pos;
        if (frame_cls != CLS_CCM) begin
          r.role = ROLE_PAYLOAD;
        end else begin
          // Walk the CCM attributes
          case (at_phase)
            AP_MSGTYPE: begin
              r.role = ROLE_MSGTYPE;
              if (b == MSG_ATTR_A || b == MSG_ATTR_B) begin
                walk_attrs = 1'b1;
                at_phase = AP_TYPE;
              end else begin
                at_phase = AP_OTHER;
              end
            end
            AP_TYPE: begin
              r.role = ROLE_ATYPE;
              if (b == ATYPE_STRING) at_phase = AP_LEN;
              else if (b == ATYPE_ONETAG) at_phase = AP_ONETAG;
              else at_phase = AP_UNKNOWN;
            end
            AP_LEN: begin
              r.role = ROLE_ALEN;
              at_left = b;
              at_phase = (b != 8'd0) ? AP_TAG : AP_TYPE;
            end
            AP_TAG: begin
              r.role = ROLE_TAG;
              cur_tag = b;
              r.tag_value = b;
              at_left = at_left - 8'd1;
              at_phase = (at_left != 8'd0) ? AP_STRING : AP_TYPE;
            end
            AP_STRING: begin
              r.role = ROLE_STRING;
              r.tag_value = cur_tag;
              at_left = at_left - 8'd1;
              if (at_left == 8'd0) at_phase = AP_TYPE;
            end
            AP_ONETAG: begin
              r.role = ROLE_TAG;
              cur_tag = b;
              r.tag_value = b;
              at_phase = AP_TYPE;
            end
            AP_UNKNOWN: begin
              r.role = ROLE_UNKNOWN;
              at_phase = AP_TYPE;
            end
            default: r.role = ROLE_OTHER;
          endcase
        end
        pay_pos  = pay_pos + 16'd1;
        pay_left = pay_left - 16'd1;
        // Close the frame; flag an attribute left unfinished
        if (pay_left == 16'd0) begin
          r.frame_last = 1'b1;
          fr_phase = FP_LEN_HI;
          if (frame_cls == CLS_CCM && walk_attrs &&
              at_phase >= AP_LEN && at_phase <= AP_UNKNOWN)
            r.truncated = 1'b1;
        end
      end
    endcase
    r.proto_class = frame_cls;
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic rs);
    stim_t s;
    s.it.data_byte = b;
    s.it.restart   = rs;
    s.drain        = drain_next;
    drain_next     = 1'b0;
    stim_q.push_back(s);
  endtask

  // Stimulus: directed frames, then random frames with some noise
  initial begin
    int unsigned kind;
    int unsigned alen;
    int unsigned cut;
    int unsigned drain_at;
    logic [15:0] flen;
    logic [7:0]  proto;
    logic [7:0]  junk;
    logic        rs;
    rst = 1'b1;

    // Empty RSL frame
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(PROTO_RSL, 1'b0);
    // CCM walk: string, single tag, zero-length string, then an unknown
    // type whose byte is cut off by the frame end
    put_byte(8'h00, 1'b0);
    put_byte(8'h0b, 1'b0);
    put_byte(PROTO_CCM, 1'b0);
    put_byte(MSG_ATTR_B, 1'b0);
    put_byte(ATYPE_STRING, 1'b0);
    put_byte(8'h03, 1'b0);
    put_byte(8'h41, 1'b0);
    put_byte(8'h42, 1'b0);
    put_byte(8'hff, 1'b0);
    put_byte(ATYPE_ONETAG, 1'b0);
    put_byte(8'h07, 1'b0);
    put_byte(ATYPE_STRING, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h09, 1'b0);
    // CCM frame with a message type that carries no attributes
    put_byte(8'h00, 1'b0);
    put_byte(8'h02, 1'b0);
    put_byte(PROTO_CCM, 1'b0);
    put_byte(8'h06, 1'b0);
    put_byte(8'haa, 1'b0);
    // Longest OML frame, broken off by a restart into an SCCP frame
    put_byte(8'hff, 1'b0);
    put_byte(8'hff, 1'b0);
    put_byte(PROTO_OML, 1'b0);
    put_byte(8'h00, 1'b1);
    put_byte(8'h01, 1'b0);
    put_byte(PROTO_SCCP, 1'b0);
    put_byte(8'h33, 1'b0);

    // Random part; start it on an empty pipeline
    drain_next = 1'b1;
    drain_at = stim_q.size() + 600;
    rs = 1'b1;
    while (stim_q.size() < N_ITEMS) begin
      if (stim_q.size() >= drain_at) begin
        drain_next = 1'b1;
        drain_at = drain_at + 600;
      end
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // Noise, then resync with a restart
        repeat ($urandom_range(1, 5)) put_byte(rand_byte(), 1'($urandom_range(0, 1)));
        rs = 1'b1;
      end else begin
        body_q.delete();
        if ($urandom_range(0, 99) < 45) begin
          proto = PROTO_CCM;
          if ($urandom_range(0, 5) == 0) begin
            body_q.push_back(rand_byte());
            repeat ($urandom_range(0, 8)) body_q.push_back(rand_byte());
          end else begin
            body_q.push_back($urandom_range(0, 1) ? MSG_ATTR_A : MSG_ATTR_B);
            repeat ($urandom_range(0, 5)) begin
              kind = $urandom_range(0, 7);
              if (kind < 4) begin
                alen = ($urandom_range(0, 30) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 6);
                body_q.push_back(ATYPE_STRING);
                body_q.push_back(alen[7:0]);
                repeat (alen) body_q.push_back(rand_byte());
              end else if (kind < 6) begin
                body_q.push_back(ATYPE_ONETAG);
                body_q.push_back(rand_byte());
              end else begin
                body_q.push_back(8'($urandom_range(2, 255)));
                body_q.push_back(rand_byte());
              end
            end
            // Now and then end the frame inside the attribute list
            if ($urandom_range(0, 5) == 0 && body_q.size() > 1)
              repeat ($urandom_range(1, body_q.size() - 1)) junk = body_q.pop_back();
          end
        end else begin
          case ($urandom_range(0, 3))
            0:       proto = PROTO_RSL;
            1:       proto = PROTO_OML;
            2:       proto = PROTO_SCCP;
            default: proto = rand_byte();
          endcase
          alen = ($urandom_range(0, 60) == 0) ? $urandom_range(256, 600)
                                              : $urandom_range(0, 16);
          repeat (alen) body_q.push_back(rand_byte());
        end
        // Prepend the header and emit, sometimes only a prefix
        flen = 16'(body_q.size());
        body_q.push_front(proto);
        body_q.push_front(flen[7:0]);
        body_q.push_front(flen[15:8]);
        rs = rs || ($urandom_range(0, 7) == 0);
        cut = body_q.size();
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, cut);
        for (int i = 0; i < cut; i++) put_byte(body_q[i], rs && i == 0);
        rs = (cut != body_q.size());
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Wait for the last transfer and its result, then let the pipe settle
    do @(posedge clk); while (stim_q.size() != 0 || item_valid || label_q.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && label_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Drive bytes; hold each until its transfer, then idle as drawn
  always @(posedge clk) begin
    stim_t s;
    if (rst) begin
      item_valid <= 1'b0;
      tx_gap   = 0;
      tx_mode  = PACE_FULL;
      tx_count = 0;
    end else begin
      if (item_valid && item_ready) begin
        tx_count++;
        if (tx_count % 50 == 0) tx_mode = $urandom_range(PACE_FULL, PACE_HEAVY);
      end
      if (!item_valid || item_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          item_valid <= 1'b0;
        end else if (stim_q.size() != 0 &&
                     !(stim_q[0].drain && (item_valid || label_q.size() != 0))) begin
          s = stim_q.pop_front();
          item <= s.it;
          item_valid <= 1'b1;
          // Keep offering while the receiver holds off
          tx_gap = (rx_hold != 0) ? 0 : pick_gap(tx_mode);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs to fill the block
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      rx_gap   = 0;
      rx_mode  = PACE_FULL;
      rx_count = 0;
      rx_hold  = 0;
    end else begin
      if (result_valid && result_ready) begin
        rx_count++;
        if (rx_count % 50 == 0) rx_mode = $urandom_range(PACE_FULL, PACE_HEAVY);
        if (rx_count == 150 || rx_count == 900) rx_hold = HOLD_CYCLES;
        rx_gap = pick_gap(rx_mode);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        result_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Predict on each byte transfer, check on each result transfer
  always @(posedge clk) begin
    result_t want;
    string   bad;
    if (rst) begin
      clear_parser();
      label_q.delete();
    end else begin
      if (item_valid && item_ready) label_q.push_back(label_byte(item));
      if (result_valid && result_ready) begin
        if (label_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result with no byte pending: %h", result);
        end else begin
          want = label_q.pop_front();
          bad = "";
          if (result.byte_out !== want.byte_out) bad = {bad, " byte_out"};
          if (result.role !== want.role) bad = {bad, " role"};
          if (result.proto_class !== want.proto_class) bad = {bad, " proto_class"};
          if (result.payload_offset !== want.payload_offset) bad = {bad, " payload_offset"};
          if (result.frame_last !== want.frame_last) bad = {bad, " frame_last"};
          if (result.tag_value !== want.tag_value) bad = {bad, " tag_value"};
          if (result.truncated !== want.truncated) bad = {bad, " truncated"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d wrong in%s", rx_count, bad);
              $display("  expected byte %h role %0d cls %0d off %0d last %b tag %h trunc %b",
                       want.byte_out, want.role, want.proto_class,
                       want.payload_offset, want.frame_last, want.tag_value,
                       want.truncated);
              $display("  actual   byte %h role %0d cls %0d off %0d last %b tag %h trunc %b",
                       result.byte_out, result.role, result.proto_class,
                       result.payload_offset, result.frame_last, result.tag_value,
                       result.truncated);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
